FILE: sv/hpam_pkg.sv
package hpam_pkg;

   localparam int SLOTS = 8;
   localparam int MAX_DIM = 16;
   localparam int SLOT_W = 3;
   localparam int POS_W = 4;
   localparam int LEN_W = 5;
   localparam int ADDR_W = SLOT_W + POS_W;
   localparam int FEAT_W = 16;
   localparam int PH_W = 13;
   localparam int TRIG_W = 16;
   localparam int IR_W = 35;
   localparam int ACC_W = 53;
   localparam int NV_W = 4;
   localparam int MAG_W = 17;
   localparam int VALUE_W = 18;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_RETRIEVE = 1'b1;

   // unit phasor, both parts signed q14
   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } phasor_type;

endpackage

FILE: sv/hpam_phasor.sv
module hpam_phasor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hpam_pkg::PH_W-1:0]   phase,
   output logic                        done,
   output hpam_pkg::phasor_type        result
);
   import hpam_pkg::*;

   localparam int X_W = 15;
   localparam int T_W = 18;
   localparam int P_W = 2 * T_W;
   localparam logic [2:0] STEP_LAST = 3'd5;

   logic                  busy_ff, busy_in;
   logic                  arg_ff, arg_in;
   logic [2:0]            step_ff, step_in;
   logic [10:0]           r_ff, r_in;
   logic [1:0]            q_ff, q_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [X_W-1:0]        x2_ff, x2_in;
   logic [X_W-1:0]        a_ff, a_in;
   logic signed [T_W-1:0] t_ff, t_in;
   logic                  done_ff, done_in;
   phasor_type            res_ff, res_in;

   logic signed [T_W-1:0] mul_a, mul_b, coef, fin;
   logic signed [P_W-1:0] prod, rnd;
   logic [11:0]           r_co;
   logic signed [TRIG_W-1:0] sa, sb;

   always_comb begin
      busy_in = busy_ff;
      arg_in  = arg_ff;
      step_in = step_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      x_in    = x_ff;
      x2_in   = x2_ff;
      a_in    = a_ff;
      t_in    = t_ff;
      done_in = 1'b0;
      res_in  = res_ff;

      mul_a = (step_ff == 3'd0 || step_ff == STEP_LAST) ? signed'({3'b000, x_ff})
                                                        : signed'({3'b000, x2_ff});
      mul_b = (step_ff == 3'd0) ? signed'({3'b000, x_ff}) : t_ff;
      prod  = mul_a * mul_b;
      rnd   = (prod + signed'(P_W'(8192))) >>> 14;

      case (step_ff)
         3'd1: coef = T_W'(77);
         3'd2: coef = T_W'(1306);
         3'd3: coef = T_W'(10583);
         3'd4: coef = T_W'(25736);
         default: coef = '0;
      endcase

      if (rnd > signed'(P_W'(16384))) begin
         fin = T_W'(16384);
      end else if (rnd < 0) begin
         fin = '0;
      end else begin
         fin = rnd[T_W-1:0];
      end

      r_co = 12'd2048 - {1'b0, r_ff};
      sa   = signed'({1'b0, a_ff});
      sb   = signed'({1'b0, fin[X_W-1:0]});

      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            arg_in  = 1'b0;
            step_in = 3'd0;
            r_in    = phase[10:0];
            q_in    = phase[12:11];
            x_in    = {1'b0, phase[10:0], 3'b000};
         end
      end else begin
         case (step_ff)
            3'd0: begin
               x2_in   = rnd[X_W-1:0];
               t_in    = T_W'(3);
               step_in = 3'd1;
            end
            STEP_LAST: begin
               if (!arg_ff) begin
                  a_in    = fin[X_W-1:0];
                  arg_in  = 1'b1;
                  x_in    = {r_co, 3'b000};
                  step_in = 3'd0;
               end else begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  case (q_ff)
                     2'd0: begin
                        res_in.s = sa;
                        res_in.c = sb;
                     end
                     2'd1: begin
                        res_in.s = sb;
                        res_in.c = -sa;
                     end
                     2'd2: begin
                        res_in.s = -sa;
                        res_in.c = -sb;
                     end
                     default: begin
                        res_in.s = -sb;
                        res_in.c = sa;
                     end
                  endcase
               end
            end
            default: begin
               t_in    = coef - rnd[T_W-1:0];
               step_in = step_ff + 3'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 3'd0;
         arg_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
         arg_ff  <= arg_in;
      end
      r_ff   <= r_in;
      q_ff   <= q_in;
      x_ff   <= x_in;
      x2_ff  <= x2_in;
      a_ff   <= a_in;
      t_ff   <= t_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: sv/hpam_mag.sv
module hpam_mag (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [hpam_pkg::ACC_W-1:0]  re,
   input  logic signed [hpam_pkg::ACC_W-1:0]  im,
   input  logic [hpam_pkg::NV_W-1:0]          nv,
   output logic                               done,
   output logic [hpam_pkg::MAG_W-1:0]         mag
);
   import hpam_pkg::*;

   localparam int RQ_W = 22;
   localparam int SQ_W = 2 * RQ_W + 2;
   localparam int DIV_W = RQ_W + 3;
   localparam int CNT_W = 5;
   localparam int MAG_MAX = 65536;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_SQ   = 3'd1;
   localparam logic [2:0] M_SUM  = 3'd2;
   localparam logic [2:0] M_ROOT = 3'd3;
   localparam logic [2:0] M_RND  = 3'd4;
   localparam logic [2:0] M_DIV  = 3'd5;
   localparam logic [2:0] M_OUT  = 3'd6;

   function automatic logic [RQ_W-1:0] round_abs(input logic signed [ACC_W-1:0] v);
      logic [ACC_W:0] a;
      logic [ACC_W:0] r;
      a = v[ACC_W-1] ? ({1'b0, ~v} + (ACC_W+1)'(1)) : {1'b0, v};
      r = (a + (ACC_W+1)'(1 << 29)) >> 30;
      return r[RQ_W-1:0];
   endfunction

   logic [2:0]        st_ff, st_in;
   logic [RQ_W-1:0]   rq_ff, rq_in, iq_ff, iq_in;
   logic [NV_W-1:0]   nv_ff, nv_in;
   logic [2*RQ_W-1:0] sqr_ff, sqr_in, sqi_ff, sqi_in;
   logic [SQ_W-1:0]   rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [DIV_W-1:0]  dv_ff, dv_in;
   logic [NV_W-1:0]   dr_ff, dr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              done_ff, done_in;

   logic [SQ_W-1:0]   trial;
   logic [NV_W:0]     tr;
   logic [DIV_W-1:0]  inc;

   always_comb begin
      st_in   = st_ff;
      rq_in   = rq_ff;
      iq_in   = iq_ff;
      nv_in   = nv_ff;
      sqr_in  = sqr_ff;
      sqi_in  = sqi_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      dv_in   = dv_ff;
      dr_in   = dr_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      done_in = 1'b0;
      trial   = root_ff + bit_ff;
      tr      = {dr_ff, dv_ff[DIV_W-1]};
      inc     = (rem_ff > root_ff) ? DIV_W'(1) : DIV_W'(0);

      case (st_ff)
         M_IDLE: begin
            if (start) begin
               rq_in = round_abs(re);
               iq_in = round_abs(im);
               nv_in = nv;
               st_in = M_SQ;
            end
         end
         M_SQ: begin
            sqr_in = rq_ff * rq_ff;
            sqi_in = iq_ff * iq_ff;
            st_in  = M_SUM;
         end
         M_SUM: begin
            rem_in  = SQ_W'(sqr_ff) + SQ_W'(sqi_ff);
            root_in = '0;
            bit_in  = SQ_W'(1) << (SQ_W - 2);
            st_in   = M_ROOT;
         end
         M_ROOT: begin
            // one result bit per cycle
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               st_in = M_RND;
            end
         end
         M_RND: begin
            // round to nearest, then add half the divisor
            dv_in  = root_ff[DIV_W-1:0] + inc + DIV_W'(nv_ff >> 1);
            dr_in  = '0;
            cnt_in = '0;
            st_in  = M_DIV;
         end
         M_DIV: begin
            if (tr >= {1'b0, nv_ff}) begin
               dr_in = NV_W'(tr - {1'b0, nv_ff});
               dv_in = {dv_ff[DIV_W-2:0], 1'b1};
            end else begin
               dr_in = tr[NV_W-1:0];
               dv_in = {dv_ff[DIV_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               st_in = M_OUT;
            end
         end
         M_OUT: begin
            mag_in  = (dv_ff > DIV_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : dv_ff[MAG_W-1:0];
            done_in = 1'b1;
            st_in   = M_IDLE;
         end
         default: begin
            st_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      rq_ff   <= rq_in;
      iq_ff   <= iq_in;
      nv_ff   <= nv_in;
      sqr_ff  <= sqr_in;
      sqi_ff  <= sqi_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      dv_ff   <= dv_in;
      dr_ff   <= dr_in;
      cnt_ff  <= cnt_in;
      mag_ff  <= mag_in;
   end

   assign done = done_ff;
   assign mag  = mag_ff;

endmodule

FILE: sv/phase_holographic_assoc_memory.sv
// Phase-coded holographic associative memory. Each feature (signed q3.12) is
// turned into the unit phasor exp(i*pi*x) once, when it arrives, by a shared
// polynomial unit, so every input transaction occupies the block until its
// phasor is done. Store vectors write their phasors into a 128-entry phasor
// memory (8 slots of up to 16 elements) with a write and a read port. When
// the last element of a retrieve vector arrives, the block correlates the
// fragment against every slot (8 * vector_length memory reads, one per cycle)
// and then, for each result element, reads the 8 slots again and runs a
// bit-serial square root and divide. With no valid slot the fragment is echoed
// element by element. Input is taken only while no vector is being worked
// on; the result register lets the last element wait on rsp_tready while new
// input is taken.
module phase_holographic_assoc_memory (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hpam_pkg::REQ_DATA_W-1:0]     req_tdata,  // slot [2:0], feature [18:3]
   input  logic                                req_tuser,  // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hpam_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // value [17:0], position [21:18]
   output logic                                rsp_tuser,  // echoed
   output logic                                rsp_tlast,  // last
   input  logic                                csr_we,
   input  logic [hpam_pkg::LEN_W-1:0]          csr_wdata   // vector_length
);
   import hpam_pkg::*;

   localparam int MP_W = TRIG_W + IR_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PHASE    = 4'd1;
   localparam logic [3:0] ST_ECHO_RD  = 4'd2;
   localparam logic [3:0] ST_ECHO_OUT = 4'd3;
   localparam logic [3:0] ST_P1       = 4'd4;
   localparam logic [3:0] ST_P1_DRAIN = 4'd5;
   localparam logic [3:0] ST_P2       = 4'd6;
   localparam logic [3:0] ST_P2_DRAIN = 4'd7;
   localparam logic [3:0] ST_MAG      = 4'd8;
   localparam logic [3:0] ST_EMIT     = 4'd9;

   // control state
   logic [3:0]        state_ff, state_in;
   logic [LEN_W-1:0]  vlen_ff, vlen_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              open_cmd_ff, open_cmd_in;
   logic [SLOT_W-1:0] open_slot_ff, open_slot_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [NV_W-1:0]   nv_ff, nv_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic [POS_W-1:0]  e_ff, e_in;

   // transaction being converted
   logic              cmd_ff, cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FEAT_W-1:0] feat_ff, feat_in;
   logic              run_ff, run_in;

   // correlation pipeline tags: stage 1 = read data, stage 2 = products
   logic              t1_v_ff, t1_v_in, t2_v_ff;
   logic [SLOT_W-1:0] t1_s_ff, t1_s_in, t2_s_ff;
   logic              t1_first_ff, t1_first_in, t2_first_ff;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_echo_ff, rsp_echo_in;
   logic                rsp_last_ff, rsp_last_in;

   // memories
   phasor_type        pmem [SLOTS*MAX_DIM];
   phasor_type        fph [MAX_DIM];
   logic [FEAT_W-1:0] fraw [MAX_DIM];
   phasor_type        pmem_rd_ff, fph_rd_ff;
   logic [FEAT_W-1:0] fraw_rd_ff;

   // per-slot correlation sums
   logic signed [IR_W-1:0]  ir_ff [SLOTS];
   logic signed [IR_W-1:0]  ii_ff [SLOTS];
   logic signed [ACC_W-1:0] re_ff, im_ff;
   logic signed [MP_W-1:0]  m1_ff, m2_ff, m3_ff, m4_ff;

   // handshake and datapath wires
   logic              in_acc, out_free, out_load, pass2, is_last, slot_end;
   logic              in_cmd, restart, vec_done;
   logic [SLOT_W-1:0] in_slot;
   logic [FEAT_W-1:0] in_feat;
   logic [LEN_W-1:0]  cnt_eff, pos_full, next_cnt;
   logic [NV_W-1:0]   nv_calc;
   logic [ADDR_W-1:0] rd_addr;
   logic [SLOT_W-1:0] ir_addr;
   logic signed [IR_W-1:0]  ir_rd, ii_rd, b1, b2;
   logic signed [MP_W:0]    add12, sub12, add34, sub34;
   logic signed [IR_W-1:0]  ir_base, ii_base;

   logic              ph_done;
   phasor_type        ph_res;
   logic              mag_done;
   logic [MAG_W-1:0]  mag_val;

   assign in_acc   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign in_cmd   = req_tuser;
   assign in_slot  = req_tdata[SLOT_W-1:0];
   assign in_feat  = req_tdata[SLOT_W +: FEAT_W];
   assign pass2    = (state_ff == ST_P2) || (state_ff == ST_P2_DRAIN);
   assign is_last  = ({1'b0, e_ff} == vlen_ff - LEN_W'(1));
   assign slot_end = (s_ff == SLOT_W'(SLOTS - 1));
   assign out_load = out_free && (state_ff == ST_EMIT || state_ff == ST_ECHO_OUT);

   // a command or slot change drops the partial vector
   assign restart  = (cnt_ff != '0) && ((in_cmd != open_cmd_ff) ||
                     (in_cmd == CMD_STORE && in_slot != open_slot_ff));
   assign cnt_eff  = restart ? '0 : cnt_ff;
   assign pos_full = (cnt_eff >= vlen_ff) ? '0 : cnt_eff;
   assign next_cnt = pos_full + LEN_W'(1);
   assign vec_done = (next_cnt >= vlen_ff);

   always_comb begin
      nv_calc = '0;
      for (int k = 0; k < SLOTS; k++) begin
         nv_calc = nv_calc + NV_W'(valid_ff[k]);
      end
   end

   hpam_phasor u_phasor (
      .clock  (clock),
      .reset  (reset),
      .start  (in_acc),
      .phase  (in_feat[PH_W-1:0]),
      .done   (ph_done),
      .result (ph_res)
   );

   hpam_mag u_mag (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_P2_DRAIN) && !t1_v_ff && !t2_v_ff),
      .re    (re_ff),
      .im    (im_ff),
      .nv    (nv_ff),
      .done  (mag_done),
      .mag   (mag_val)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      vlen_in      = vlen_ff;
      cnt_in       = cnt_ff;
      open_cmd_in  = open_cmd_ff;
      open_slot_in = open_slot_ff;
      valid_in     = valid_ff;
      nv_in        = nv_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      pos_in       = pos_ff;
      feat_in      = feat_ff;
      run_in       = run_ff;
      t1_v_in      = 1'b0;
      t1_s_in      = s_ff;
      t1_first_in  = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               if (cnt_eff == '0) begin
                  open_cmd_in  = in_cmd;
                  open_slot_in = in_slot;
               end
               cnt_in  = vec_done ? '0 : next_cnt;
               cmd_in  = in_cmd;
               slot_in = in_slot;
               pos_in  = pos_full[POS_W-1:0];
               feat_in = in_feat;
               run_in  = (in_cmd == CMD_RETRIEVE) && vec_done;
               if (in_cmd == CMD_STORE && vec_done) begin
                  valid_in[in_slot] = 1'b1;
               end
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (ph_done) begin
               nv_in = nv_calc;
               s_in  = '0;
               e_in  = '0;
               if (!run_ff) begin
                  state_in = ST_IDLE;
               end else if (nv_calc == '0) begin
                  state_in = ST_ECHO_RD;
               end else begin
                  state_in = ST_P1;
               end
            end
         end
         ST_ECHO_RD: begin
            state_in = ST_ECHO_OUT;
         end
         ST_ECHO_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_W'(signed'(fraw_rd_ff));
               rsp_pos_in   = e_ff;
               rsp_echo_in  = 1'b1;
               rsp_last_in  = is_last;
               e_in         = e_ff + POS_W'(1);
               state_in     = is_last ? ST_IDLE : ST_ECHO_RD;
            end
         end
         ST_P1: begin
            // fragment against each slot, element index inner
            t1_v_in     = 1'b1;
            t1_first_in = (e_ff == '0);
            if (is_last) begin
               e_in = '0;
               s_in = s_ff + SLOT_W'(1);
               if (slot_end) begin
                  state_in = ST_P1_DRAIN;
               end
            end else begin
               e_in = e_ff + POS_W'(1);
            end
         end
         ST_P1_DRAIN: begin
            if (!t1_v_ff && !t2_v_ff) begin
               s_in     = '0;
               e_in     = '0;
               state_in = ST_P2;
            end
         end
         ST_P2: begin
            // one result element, slot index inner
            t1_v_in     = 1'b1;
            t1_first_in = (s_ff == '0);
            s_in        = s_ff + SLOT_W'(1);
            if (slot_end) begin
               state_in = ST_P2_DRAIN;
            end
         end
         ST_P2_DRAIN: begin
            if (!t1_v_ff && !t2_v_ff) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            if (mag_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_W'(mag_val);
               rsp_pos_in   = e_ff;
               rsp_echo_in  = 1'b0;
               rsp_last_in  = is_last;
               e_in         = e_ff + POS_W'(1);
               s_in         = '0;
               state_in     = is_last ? ST_IDLE : ST_P2;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // length write: 0 reads as 1, beyond the depth reads as the depth
      if (csr_we) begin
         if (csr_wdata == '0) begin
            vlen_in = LEN_W'(1);
         end else if (csr_wdata > LEN_W'(MAX_DIM)) begin
            vlen_in = LEN_W'(MAX_DIM);
         end else begin
            vlen_in = csr_wdata;
         end
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vlen_ff      <= LEN_W'(MAX_DIM);
         cnt_ff       <= '0;
         open_cmd_ff  <= CMD_STORE;
         open_slot_ff <= '0;
         valid_ff     <= '0;
         nv_ff        <= '0;
         s_ff         <= '0;
         e_ff         <= '0;
         run_ff       <= 1'b0;
         t1_v_ff      <= 1'b0;
         t2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vlen_ff      <= vlen_in;
         cnt_ff       <= cnt_in;
         open_cmd_ff  <= open_cmd_in;
         open_slot_ff <= open_slot_in;
         valid_ff     <= valid_in;
         nv_ff        <= nv_in;
         s_ff         <= s_in;
         e_ff         <= e_in;
         run_ff       <= run_in;
         t1_v_ff      <= t1_v_in;
         t2_v_ff      <= t1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      pos_ff       <= pos_in;
      feat_ff      <= feat_in;
      t1_s_ff      <= t1_s_in;
      t1_first_ff  <= t1_first_in;
      t2_s_ff      <= t1_s_ff;
      t2_first_ff  <= t1_first_ff;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_echo_ff  <= rsp_echo_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // phasor and fragment memories, registered reads
   assign rd_addr = {s_ff, e_ff};

   always_ff @(posedge clock) begin
      if (ph_done && cmd_ff == CMD_STORE) begin
         pmem[{slot_ff, pos_ff}] <= ph_res;
      end
      pmem_rd_ff <= pmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ph_done && cmd_ff == CMD_RETRIEVE) begin
         fph[pos_ff]  <= ph_res;
         fraw[pos_ff] <= feat_ff;
      end
      fph_rd_ff  <= fph[e_ff];
      fraw_rd_ff <= fraw[e_ff];
   end

   // products stage: same four multipliers serve both passes
   assign ir_addr = pass2 ? t1_s_ff : t2_s_ff;
   assign ir_rd   = ir_ff[ir_addr];
   assign ii_rd   = ii_ff[ir_addr];
   assign b1      = pass2 ? ir_rd : IR_W'(fph_rd_ff.c);
   assign b2      = pass2 ? ii_rd : IR_W'(fph_rd_ff.s);

   always_ff @(posedge clock) begin
      m1_ff <= pmem_rd_ff.c * b1;
      m2_ff <= pmem_rd_ff.s * b2;
      m3_ff <= pmem_rd_ff.c * b2;
      m4_ff <= pmem_rd_ff.s * b1;
   end

   // accumulate stage
   assign add12   = m1_ff + m2_ff;
   assign sub12   = m1_ff - m2_ff;
   assign add34   = m3_ff + m4_ff;
   assign sub34   = m3_ff - m4_ff;
   assign ir_base = t2_first_ff ? '0 : ir_rd;
   assign ii_base = t2_first_ff ? '0 : ii_rd;

   always_ff @(posedge clock) begin
      if (t2_v_ff) begin
         if (!pass2) begin
            ir_ff[t2_s_ff] <= ir_base + signed'(add12[IR_W-1:0]);
            ii_ff[t2_s_ff] <= ii_base + signed'(sub34[IR_W-1:0]);
         end else if (valid_ff[t2_s_ff]) begin
            re_ff <= (t2_first_ff ? '0 : re_ff) + ACC_W'(sub12);
            im_ff <= (t2_first_ff ? '0 : im_ff) + ACC_W'(add34);
         end else if (t2_first_ff) begin
            re_ff <= '0;
            im_ff <= '0;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - POS_W){1'b0}}, rsp_pos_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_echo_ff;
   assign rsp_tlast  = rsp_last_ff;

   // element counter never reaches the vector length
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < vlen_ff)
      else $error("element count out of range");

   // phasor unit only finishes while the sequencer waits for it
   a_phasor_done: assert property (@(posedge clock) disable iff (reset)
      ph_done |-> state_ff == ST_PHASE)
      else $error("unexpected phasor completion");

   // magnitude unit only finishes while the sequencer waits for it
   a_mag_done: assert property (@(posedge clock) disable iff (reset)
      mag_done |-> state_ff == ST_MAG)
      else $error("unexpected magnitude completion");

   // correlation runs only with at least one valid slot
   a_p2_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_P2 |-> nv_ff != '0 && valid_ff != '0)
      else $error("correlation with empty memory");

endmodule
